>>> sv/charge_to_tot_digitizer_defines.svh
// Assertion macros shared by the digitizer RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef CHARGE_TO_TOT_DIGITIZER_DEFINES_SVH
`define CHARGE_TO_TOT_DIGITIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("digitizer check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define CTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("digitizer check failed: next-cycle implication");

`endif

>>> sv/ctd_pkg.sv
// Types, field widths, register codes and reset values of the ToT digitizer.
// No dependencies; compile first after the defines header.
package ctd_pkg;

   localparam int CHARGE_BITS    = 20;
   localparam int GAIN_FRAC_BITS = 20;
   localparam int MAX_TOT_BITS   = 16;

   localparam int THRESH_W   = 16;
   localparam int GAIN_W     = 20;
   localparam int TOT_BITS_W = 5;
   localparam int MODE_W     = 2;
   localparam int RND_W      = 20;
   localparam int CODE_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 16'd600;
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 20'd11185;
   localparam logic [TOT_BITS_W-1:0] TOT_BITS_RESET = 5'd8;
   localparam logic [TOT_BITS_W-1:0] TOT_BITS_MIN   = 5'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR = 2'd0,
      MODE_KINKED = 2'd1,
      MODE_LOG    = 2'd2,
      MODE_STOCH  = 2'd3
   } tot_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_GAIN      = 2'd1,
      CSR_TOT_BITS  = 2'd2,
      CSR_TOT_MODE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHARGE_BITS-1:0] charge_electrons;
      logic [RND_W-1:0]       random_fraction;
   } req_data_type;

   typedef struct packed {
      logic [CODE_W-1:0] tot_code;
      logic              hit;
   } rsp_data_type;

endpackage

>>> sv/charge_to_tot_digitizer.sv
// Top level of the pixel charge to time-over-threshold digitizer.
// Depends on ctd_pkg and charge_to_tot_digitizer_defines.svh.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------------
//  request  | start, busy, req_data          | beat taken when start && !busy
//  response | rsp_strobe, rsp_data           | one-cycle strobe, receiver cannot stall
//  config   | csr_we, csr_index, csr_wdata   | written on any edge with csr_we high
//
// Throughput is one beat per clock; busy never rises. The stage 1 registers
// hold the threshold-subtracted charge; the response registers hold the
// code after the gain multiply (one GAIN_W x CHARGE_BITS multiplier) and
// the mode encoder, which sets the critical path.
// Reset (synchronous, active high) restores the register defaults and drops
// any beat in flight. There is no stall path: each request yields exactly
// one response strobe, from the response registers.
module charge_to_tot_digitizer #(
   parameter int GAIN_FRAC_BITS = ctd_pkg::GAIN_FRAC_BITS,
   parameter int MAX_TOT_BITS   = ctd_pkg::MAX_TOT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  ctd_pkg::req_data_type              req_data,
   // response channel
   output logic                               rsp_strobe,
   output ctd_pkg::rsp_data_type              rsp_data,
   // configuration port
   input  logic                               csr_we,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ctd_pkg::*;

   `include "charge_to_tot_digitizer_defines.svh"

   // product of gain and charge excess, and its integer part
   localparam int PROD_W = GAIN_W + CHARGE_BITS;
   localparam int INT_W  = PROD_W - GAIN_FRAC_BITS;
   // compare width wide enough for both the integer part and the code range
   localparam int CMP_W  = ((INT_W > MAX_TOT_BITS) ? INT_W : MAX_TOT_BITS) + 2;
   localparam int LOG_W  = $clog2(INT_W);
   localparam int CMP_FRAC_W = GAIN_FRAC_BITS + RND_W;

   // ---------------------------------------------------------------- config
   logic [THRESH_W-1:0]   threshold_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [TOT_BITS_W-1:0] tot_bits_ff;
   tot_mode_type          tot_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         gain_ff      <= GAIN_RESET;
         tot_bits_ff  <= TOT_BITS_RESET;
         tot_mode_ff  <= MODE_LINEAR;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_GAIN:      gain_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_TOT_BITS:  tot_bits_ff  <= csr_wdata[TOT_BITS_W-1:0];
            CSR_TOT_MODE:  tot_mode_ff  <= tot_mode_type'(csr_wdata[MODE_W-1:0]);
            default: ;
         endcase
      end
   end

   // clamp the code width to [2, MAX_TOT_BITS] and derive the code range
   logic [TOT_BITS_W-1:0] n_width;
   logic [CMP_W-1:0]      half_x;
   logic [CMP_W-1:0]      top_x;

   always_comb begin
      if (tot_bits_ff < TOT_BITS_MIN) begin
         n_width = TOT_BITS_MIN;
      end else if (tot_bits_ff > TOT_BITS_W'(MAX_TOT_BITS)) begin
         n_width = TOT_BITS_W'(MAX_TOT_BITS);
      end else begin
         n_width = tot_bits_ff;
      end
      half_x = CMP_W'(1) << (n_width - TOT_BITS_W'(1));
      top_x  = (CMP_W'(1) << n_width) - CMP_W'(1);
   end

   // ---------------------------------------------------------------- stage 1
   // subtract the threshold on the way in
   logic                   s1_valid_ff;
   logic                   s1_neg_ff;
   logic [CHARGE_BITS-1:0] s1_mag_ff;
   logic [RND_W-1:0]       s1_rnd_ff;

   logic                   accept;
   logic                   neg_in;
   logic [CHARGE_BITS-1:0] mag_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      neg_in = req_data.charge_electrons < CHARGE_BITS'(threshold_ff);
      mag_in = neg_in ? '0 : req_data.charge_electrons - CHARGE_BITS'(threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_neg_ff <= neg_in;
         s1_mag_ff <= mag_in;
         s1_rnd_ff <= req_data.random_fraction;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // floor(log2(v)) for v >= 1: priority encode the top set bit
   function automatic logic [LOG_W-1:0] flog2(input logic [INT_W-1:0] v);
      logic [LOG_W-1:0] r;
      r = '0;
      for (int i = 0; i < INT_W; i++) begin
         if (v[i]) r = LOG_W'(i);
      end
      return r;
   endfunction

   logic [PROD_W-1:0]         prod;
   logic [INT_W-1:0]          int_part;
   logic [GAIN_FRAC_BITS-1:0] frac_part;
   logic [CMP_W-1:0]          int_x;
   logic [CMP_W-1:0]          lin_x;
   logic [CMP_W-1:0]          kink_x;
   logic [CMP_W-1:0]          log_x;
   logic [CMP_W-1:0]          stoch_x;
   logic [CMP_W-1:0]          code_x;
   logic [INT_W-1:0]          log_arg;
   logic [CMP_FRAC_W-1:0]     rnd_scaled;
   logic [CMP_FRAC_W-1:0]     frac_scaled;
   logic                      round_up;
   logic                      above_knee;

   always_comb begin
      prod      = PROD_W'(gain_ff) * PROD_W'(s1_mag_ff);
      int_part  = prod[PROD_W-1:GAIN_FRAC_BITS];
      frac_part = prod[GAIN_FRAC_BITS-1:0];
      int_x     = CMP_W'(int_part);

      // linear: saturate at top-1, then offset by one
      lin_x = ((int_x > top_x - CMP_W'(1)) ? top_x - CMP_W'(1) : int_x) + CMP_W'(1);

      // aQ >= H exactly when the integer part reaches H
      above_knee = int_x >= half_x;

      // kinked: half slope beyond the knee
      kink_x = ((int_x - half_x) >> 1) + half_x + CMP_W'(1);
      if (kink_x > top_x) kink_x = top_x;

      // log tail: floor(log2(1 + aQ - H)) taken on the integer part
      log_arg = INT_W'(int_x - half_x + CMP_W'(1));
      log_x   = CMP_W'(flog2(log_arg)) + half_x + CMP_W'(1);
      if (log_x > top_x) log_x = top_x;

      // stochastic: round up when the random fraction lies below frac(aQ)
      rnd_scaled  = {s1_rnd_ff, {GAIN_FRAC_BITS{1'b0}}};
      frac_scaled = {frac_part, {RND_W{1'b0}}};
      round_up    = rnd_scaled < frac_scaled;
      if (s1_mag_ff == '0) begin
         stoch_x = '0;
      end else if (int_x >= top_x - CMP_W'(1)) begin
         stoch_x = top_x - CMP_W'(1);
      end else begin
         stoch_x = int_x + CMP_W'(round_up);
      end

      case (tot_mode_ff)
         MODE_LINEAR: code_x = s1_neg_ff ? '0 : lin_x;
         MODE_KINKED: code_x = s1_neg_ff ? '0 : (above_knee ? kink_x : lin_x);
         MODE_LOG:    code_x = s1_neg_ff ? '0 : (above_knee ? log_x : lin_x);
         MODE_STOCH:  code_x = stoch_x;
         default:     code_x = '0;
      endcase
   end

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;

   always_comb begin
      rsp_data_in.tot_code = CODE_W'(code_x);
      rsp_data_in.hit      = code_x != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // hold the last code between strobes
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `CTD_ASSERT_NEXT(a_stage_advance, clock, reset, s1_valid_ff, rsp_strobe)
   `CTD_ASSERT_NOW(a_rsp_from_req, clock, reset, rsp_strobe, $past(start, 2))
   `CTD_ASSERT_NOW(a_hit_matches, clock, reset, rsp_strobe,
                   rsp_data.hit == (rsp_data.tot_code != '0))
   `CTD_ASSERT_NOW(a_code_in_range, clock, reset, rsp_strobe,
                   CMP_W'(rsp_data.tot_code) <= top_x)
   `CTD_ASSERT_NOW(a_stoch_below_top, clock, reset,
                   rsp_strobe && tot_mode_ff == MODE_STOCH,
                   CMP_W'(rsp_data.tot_code) < top_x)

endmodule

>>> sim/tot_code_checker.sv
// Checker for the charge to ToT digitizer: mirrors the registers, predicts every code.
// Depends on ctd_pkg; instantiated beside the block by tb_charge_to_tot_digitizer.
module tot_code_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  ctd_pkg::req_data_type          req_data,
   input  logic                           rsp_strobe,
   input  ctd_pkg::rsp_data_type          rsp_data,
   input  logic                           csr_we,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             code_mismatches,
   output int                             codes_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   import ctd_pkg::*;

   logic [THRESH_W-1:0]   thr_q;
   logic [GAIN_W-1:0]     gain_q;
   logic [TOT_BITS_W-1:0] width_q;
   tot_mode_type          mode_q;
   rsp_data_type          expected_codes[$];

   function automatic rsp_data_type tot_code_for(
      input logic [CHARGE_BITS-1:0] charge,
      input logic [RND_W-1:0]       frac,
      input logic [THRESH_W-1:0]    thr,
      input logic [GAIN_W-1:0]      g,
      input logic [TOT_BITS_W-1:0]  width_cfg,
      input tot_mode_type           mode
   );
      int unsigned  n;
      int unsigned  lg;
      logic [63:0]  half, top, p, lin, knee, m, code, fr;
      bit           below, at_thr;
      rsp_data_type r;
      n = (width_cfg < TOT_BITS_MIN) ? 2 :
          ((width_cfg > MAX_TOT_BITS) ? MAX_TOT_BITS : width_cfg);
      half   = 64'd1 << (n - 1);
      top    = (64'd1 << n) - 1;
      below  = charge < thr;
      at_thr = charge == thr;
      p      = below ? 64'd0 : 64'(g) * (64'(charge) - 64'(thr));
      lin    = p >> GAIN_FRAC_BITS;
      if (lin > top - 1) lin = top - 1;
      lin  = lin + 1;
      knee = half << GAIN_FRAC_BITS;
      code = 64'd0;
      case (mode)
         MODE_LINEAR: begin
            code = below ? 64'd0 : lin;
         end
         MODE_KINKED: begin
            if (below) code = 64'd0;
            else if (p < knee) code = lin;
            else begin
               // half slope above the knee
               code = ((p - knee) >> (GAIN_FRAC_BITS + 1)) + half + 1;
               if (code > top) code = top;
            end
         end
         MODE_LOG: begin
            if (below) code = 64'd0;
            else if (p < knee) code = lin;
            else begin
               m  = p - knee + (64'd1 << GAIN_FRAC_BITS);
               lg = 0;
               for (int i = 0; i < 64; i++) if (m[i]) lg = i;
               code = 64'(lg) - GAIN_FRAC_BITS + half + 1;
               if (code > top) code = top;
            end
         end
         default: begin
            if (below || at_thr) code = 64'd0;
            else if (p >= ((top - 1) << GAIN_FRAC_BITS)) code = top - 1;
            else begin
               fr   = p & ((64'd1 << GAIN_FRAC_BITS) - 1);
               code = (p >> GAIN_FRAC_BITS) + ((64'(frac) < fr) ? 64'd1 : 64'd0);
            end
         end
      endcase
      r.tot_code = code[CODE_W-1:0];
      r.hit      = code != 64'd0;
      return r;
   endfunction

   always @(posedge clock) begin : track_codes
      rsp_data_type want;
      if (reset) begin
         thr_q           = THRESH_RESET;
         gain_q          = GAIN_RESET;
         width_q         = TOT_BITS_RESET;
         mode_q          = MODE_LINEAR;
         code_mismatches = 0;
         expected_codes.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_codes.size() == 0) begin
               code_mismatches++;
               if (code_mismatches <= 10)
                  $display("%0t: unexpected result tot_code=%0d hit=%0b",
                           $realtime, rsp_data.tot_code, rsp_data.hit);
            end else begin
               want = expected_codes.pop_front();
               if (want.tot_code !== rsp_data.tot_code || want.hit !== rsp_data.hit) begin
                  code_mismatches++;
                  if (code_mismatches <= 10)
                     $display("%0t: tot_code exp %0d got %0d, hit exp %0b got %0b",
                              $realtime, want.tot_code, rsp_data.tot_code,
                              want.hit, rsp_data.hit);
               end
            end
         end
         if (start && !busy)
            expected_codes = {expected_codes,
                              tot_code_for(req_data.charge_electrons,
                                           req_data.random_fraction,
                                           thr_q, gain_q, width_q, mode_q)};
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: thr_q   = csr_wdata[THRESH_W-1:0];
               CSR_GAIN:      gain_q  = csr_wdata[GAIN_W-1:0];
               CSR_TOT_BITS:  width_q = csr_wdata[TOT_BITS_W-1:0];
               CSR_TOT_MODE:  mode_q  = tot_mode_type'(csr_wdata[MODE_W-1:0]);
               default: ;
            endcase
         end
      end
      codes_in_flight <= reset ? 0 : expected_codes.size();
   end

endmodule

>>> sim/tb_charge_to_tot_digitizer.sv
// Testbench top of the charge to ToT digitizer: clock, reset, stimulus and verdict.
// Depends on ctd_pkg, charge_to_tot_digitizer and tot_code_checker.
module tb_charge_to_tot_digitizer;
   timeunit 1ns;
   timeprecision 1ps;
   import ctd_pkg::*;

   localparam int NUM_SETUPS      = 12;
   localparam int BEATS_PER_SETUP = 80;
   localparam logic [CHARGE_BITS-1:0] CHARGE_MAX = '1;
   localparam logic [RND_W-1:0]       FRAC_MAX   = '1;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_data_type          req_data;
   logic                  rsp_strobe;
   rsp_data_type          rsp_data;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    code_mismatches;
   int                    codes_in_flight;

   // Our own copy of the settings, used only to aim charges at the knee and
   // the saturation point; the checker keeps its own mirror for prediction.
   logic [THRESH_W-1:0]   cur_thr;
   logic [GAIN_W-1:0]     cur_gain;
   logic [TOT_BITS_W-1:0] cur_width;
   bit                    gaps_on;

   charge_to_tot_digitizer DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tot_code_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .code_mismatches (code_mismatches),
      .codes_in_flight (codes_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: the slowest legal run is well under 100 us.
   initial begin
      #2_000_000;
      $display("** charge_to_tot_digitizer: FAILED **");
      $finish;
   end

   // Write one register; call at a rising edge, leaves the write enable high
   // so that back-to-back writes never toggle it within one step.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Load a full setting. Junk goes into the unused upper data bits of the
   // narrow registers: the block must keep only the low bits.
   task automatic load_setup(input logic [THRESH_W-1:0] thr, input logic [GAIN_W-1:0] g,
                             input logic [TOT_BITS_W-1:0] width, input tot_mode_type mode);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_THRESHOLD, {junk[CSR_DATA_W-1:THRESH_W], thr});
      write_reg(CSR_GAIN, g);
      write_reg(CSR_TOT_BITS, {junk[CSR_DATA_W-1:TOT_BITS_W], width});
      write_reg(CSR_TOT_MODE, {junk[CSR_DATA_W-1:MODE_W], mode});
      csr_we    <= 1'b0;
      cur_thr   = thr;
      cur_gain  = g;
      cur_width = width;
   endtask

   // Present one beat and hold it until the block takes it; returns at the
   // accepting edge with start still high, ready for the next beat.
   task automatic send_charge(input logic [CHARGE_BITS-1:0] charge,
                              input logic [RND_W-1:0] frac);
      if (gaps_on && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{charge_electrons: charge, random_fraction: frac};
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every code has come back, then idle on
   // so that any stray strobe is still caught.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (codes_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Aim charges at the interesting spots of the current transfer curve.
   function automatic logic [CHARGE_BITS-1:0] pick_charge();
      int unsigned n;
      longint      c;
      longint      half;
      int unsigned sel;
      n    = (cur_width < TOT_BITS_MIN) ? 2 :
             ((cur_width > MAX_TOT_BITS) ? MAX_TOT_BITS : cur_width);
      half = longint'(1) << (n - 1);
      sel  = $urandom_range(0, 99);
      c    = longint'(CHARGE_BITS'($urandom));
      if (sel < 10)
         c = (cur_thr == 0) ? 0 : $urandom_range(0, cur_thr - 1);
      else if (sel < 25)
         c = longint'(cur_thr) + $urandom_range(0, 4) - 2;
      else if (sel < 45 && cur_gain != 0)
         c = longint'(cur_thr) + ((half << GAIN_FRAC_BITS) / cur_gain)
             + $urandom_range(0, 6) - 3;
      else if (sel < 60 && cur_gain != 0)
         c = longint'(cur_thr) + (((2 * half - 2) << GAIN_FRAC_BITS) / cur_gain)
             + $urandom_range(0, 6) - 3;
      else if (sel < 80)
         c = longint'(cur_thr) + $urandom_range(0, 3000);
      if (c < 0) c = 0;
      if (c > longint'(CHARGE_MAX)) c = longint'(CHARGE_MAX);
      return CHARGE_BITS'(c);
   endfunction

   function automatic logic [RND_W-1:0] pick_fraction();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return FRAC_MAX;
      return RND_W'($urandom);
   endfunction

   // Random setting, with the register extremes drawn often.
   task automatic random_setup();
      logic [THRESH_W-1:0]   thr;
      logic [GAIN_W-1:0]     g;
      logic [TOT_BITS_W-1:0] width;
      case ($urandom_range(0, 3))
         0:       thr = '0;
         1:       thr = '1;
         2:       thr = THRESH_W'($urandom_range(0, 2000));
         default: thr = THRESH_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       g = '0;
         1:       g = '1;
         2:       g = GAIN_W'($urandom_range(1, 64));
         3:       g = GAIN_W'($urandom_range(1000, 60000));
         default: g = GAIN_W'($urandom);
      endcase
      width = ($urandom_range(0, 4) == 0) ? TOT_BITS_W'($urandom)
                                          : TOT_BITS_W'($urandom_range(2, 16));
      load_setup(thr, g, width, tot_mode_type'($urandom_range(0, 3)));
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      cur_thr   = THRESH_RESET;
      cur_gain  = GAIN_RESET;
      cur_width = TOT_BITS_RESET;
      gaps_on   = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset setting, linear mode: below, at and just above threshold,
      // a charge just past saturation, and full-scale charge.
      send_charge('0, '0);
      send_charge(20'd599, FRAC_MAX);
      send_charge(20'd600, '0);
      send_charge(20'd601, '0);
      send_charge(20'd24600, 20'h80000);
      send_charge(CHARGE_MAX, FRAC_MAX);
      drain();

      // Kinked, widest code, zero threshold, largest gain.
      load_setup('0, '1, 5'd16, MODE_KINKED);
      send_charge('0, '0);
      send_charge(20'd1, '0);
      send_charge(20'd40000, FRAC_MAX);
      send_charge(CHARGE_MAX, '0);
      drain();

      // Log tail with a width below the minimum, taken as two bits.
      load_setup('1, '1, 5'd0, MODE_LOG);
      send_charge(20'd65535, '0);
      send_charge(20'd65537, '0);
      send_charge(20'd65538, '0);
      send_charge(20'd65540, '0);
      send_charge(CHARGE_MAX, '0);
      drain();

      // Stochastic with zero gain and a width above the maximum.
      load_setup(16'd100, '0, 5'd31, MODE_STOCH);
      send_charge(20'd100, '0);
      send_charge(20'd101, '0);
      send_charge(CHARGE_MAX, FRAC_MAX);
      drain();

      // Stochastic rounding of exactly one half, both sides of the draw,
      // then saturation.
      load_setup(16'd1000, 20'd524288, 5'd4, MODE_STOCH);
      send_charge(20'd1001, '0);
      send_charge(20'd1001, 20'h80000);
      send_charge(20'd1001, 20'h7FFFF);
      send_charge(20'd1029, FRAC_MAX);
      send_charge(CHARGE_MAX, '0);
      drain();

      // Random settings, each followed by a run of aimed charges. Two of the
      // runs go without any idle cycles.
      for (int s = 0; s < NUM_SETUPS; s++) begin
         random_setup();
         gaps_on = !(s == 5 || s == 6);
         for (int b = 0; b < BEATS_PER_SETUP; b++)
            send_charge(pick_charge(), pick_fraction());
         drain();
      end

      repeat (8) @(posedge clock);
      if (code_mismatches == 0)
         $display("** charge_to_tot_digitizer: PASSED **");
      else
         $display("** charge_to_tot_digitizer: FAILED **");
      $finish;
   end

endmodule
